FILE: src/plws_pkg.sv
// Package for the positional list with sort: operation and status codes,
// the controller state type and the per-cell control struct.
// No dependencies; every other file in src depends on it.
package plws_pkg;

  localparam int OP_W     = 2;
  localparam int POS_W    = 7;
  localparam int POS_MAG_W = 6;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_SORT   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SORT
  } state_t;

  // What one cell does in a cycle; at most one bit is set, none means hold.
  typedef struct packed {
    logic take_left;
    logic take_value;
    logic take_right;
    logic keep_min;
    logic keep_max;
  } cell_ctrl_t;

endpackage

FILE: src/plws_if.sv
// Request and response channel interfaces of the positional list with sort.
// Depends on plws_pkg for the field widths.
interface plws_req_if;
  logic                         valid;
  logic                         ready;
  logic [plws_pkg::OP_W-1:0]    operation;
  logic signed [plws_pkg::POS_W-1:0] position;
  logic signed [plws_pkg::VAL_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink (input valid, input operation, input position, input value,
                output ready);
endinterface

interface plws_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [plws_pkg::STATUS_W-1:0]     status;
  logic signed [plws_pkg::VAL_W-1:0] read_value;
  logic [plws_pkg::CNT_W-1:0]        count;

  modport source (output valid, output status, output read_value, output count,
                  input ready);
  modport sink (input valid, input status, input read_value, input count,
                output ready);
endinterface

FILE: src/plws_cell.sv
// One storage cell of the list: holds a single element and takes a new one
// from its neighbours, the request, or a compare-exchange with a neighbour.
// Depends on plws_pkg.
module plws_cell (
  input  logic              clk,
  input  plws_pkg::cell_ctrl_t ctrl,
  input  logic signed [plws_pkg::VAL_W-1:0] left_val,
  input  logic signed [plws_pkg::VAL_W-1:0] right_val,
  input  logic signed [plws_pkg::VAL_W-1:0] ins_val,
  output logic signed [plws_pkg::VAL_W-1:0] val
);
  import plws_pkg::*;

  logic signed [VAL_W-1:0] val_next;

  // The pair swaps when its right element is below its left one; both cells
  // of the pair evaluate that same comparison.
  always_comb begin
    val_next = val;
    if (ctrl.take_left) begin
      val_next = left_val;
    end else if (ctrl.take_value) begin
      val_next = ins_val;
    end else if (ctrl.take_right) begin
      val_next = right_val;
    end else if (ctrl.keep_min) begin
      if (right_val < val) begin
        val_next = right_val;
      end
    end else if (ctrl.keep_max) begin
      if (val < left_val) begin
        val_next = left_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: src/positional_list_with_sort.sv
// Positional list with sort: top level, a row of element cells and the
// controller. Depends on plws_pkg, plws_if.sv and plws_cell.
//
// Requests arrive on the req channel (operation, position, value) and each
// produces exactly one response on the rsp channel (status, read_value and
// the element count after the request); a transfer happens when valid and
// ready are both high. Insert, delete and read are done in the cycle of the
// request transfer, and their response is registered then. Sort runs
// an odd-even transposition over the cell row, one round per cycle, and its
// response is registered together with the last round. No request is taken
// while a sort runs. A request is taken when the controller is idle and the
// response register is empty or is being emptied in the same cycle, so a
// stalled receiver holds the response and blocks further requests. Reset
// clears the count, the controller and the response valid flag; cell
// contents are left as they are, since only cells below the count are ever
// read.
module positional_list_with_sort #(
  parameter int DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  plws_req_if.sink   req,
  plws_rsp_if.source rsp
);
  import plws_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > POS_MAG_W) ? CW : POS_MAG_W;

  state_t state;
  state_t state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] sort_cnt;

  logic req_fire;
  logic sort_active;
  logic sort_done;

  logic signed [VAL_W-1:0] cell_val  [DEPTH];
  logic signed [VAL_W-1:0] left_val  [DEPTH];
  logic signed [VAL_W-1:0] right_val [DEPTH];
  cell_ctrl_t              cell_ctrl [DEPTH];

  logic                pos_neg;
  logic [CMPW-1:0]     pos_mag;
  logic [CMPW-1:0]     cnt_c;
  logic [CMPW-1:0]     ins_idx;
  logic                pos_in_list;
  logic                do_insert;
  logic                do_delete;
  logic [STATUS_W-1:0] status_d;
  logic signed [VAL_W-1:0] rd_sel;
  logic signed [VAL_W-1:0] rd_d;

  assign req_fire = req.valid && req.ready;
  assign sort_done = sort_active && (sort_cnt == IW'(DEPTH - 1));

  // Controller: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && req.operation == OP_SORT) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        if (sort_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller: outputs.
  always_comb begin
    req.ready   = 1'b0;
    sort_active = 1'b0;
    unique case (state)
      ST_IDLE: req.ready = !rst && (!rsp.valid || rsp.ready);
      ST_SORT: sort_active = 1'b1;
      default: begin
        req.ready   = 1'b0;
        sort_active = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sort_cnt <= '0;
    end else begin
      state <= state_next;
      if (sort_active) begin
        sort_cnt <= sort_done ? '0 : sort_cnt + 1'b1;
      end
    end
  end

  // Request decode and range checks.
  assign pos_neg     = req.position[POS_W-1];
  assign pos_mag     = CMPW'(req.position[POS_MAG_W-1:0]);
  assign cnt_c       = CMPW'(count);
  assign pos_in_list = !pos_neg && (pos_mag < cnt_c);
  assign ins_idx     = pos_neg ? '0 : pos_mag + 1'b1;

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_mag == CMPW'(i)) begin
        rd_sel = cell_val[i];
      end
    end
  end

  always_comb begin
    status_d   = STATUS_OK;
    rd_d       = '0;
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    count_next = count;
    unique case (req.operation)
      OP_INSERT: begin
        if (!(pos_in_list || req.position == {POS_W{1'b1}})) begin
          status_d = STATUS_RANGE;
        end else if (count == CW'(DEPTH)) begin
          status_d = STATUS_FULL;
        end else begin
          do_insert  = req_fire;
          count_next = count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (!pos_in_list) begin
          status_d = STATUS_RANGE;
        end else begin
          do_delete  = req_fire;
          count_next = count - 1'b1;
        end
      end
      OP_READ: begin
        if (!pos_in_list) begin
          status_d = STATUS_RANGE;
        end else begin
          rd_d = rd_sel;
        end
      end
      OP_SORT: status_d = STATUS_OK;
      default: status_d = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req_fire) begin
      count <= count_next;
    end
  end

  // Per-cell actions. In a sort round, pairs start at even or odd cells by
  // the round's parity, and only pairs lying wholly inside the list take part.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i] = '0;
      if (do_insert) begin
        cell_ctrl[i].take_value = (CMPW'(i) == ins_idx);
        cell_ctrl[i].take_left  = (CMPW'(i) > ins_idx);
      end
      if (do_delete) begin
        cell_ctrl[i].take_right = (CMPW'(i) >= pos_mag);
      end
      if (sort_active) begin
        cell_ctrl[i].keep_min = ((i % 2) == int'(sort_cnt[0])) &&
                                (CMPW'(i + 1) < cnt_c);
        cell_ctrl[i].keep_max = (i >= 1) && ((i % 2) != int'(sort_cnt[0])) &&
                                (CMPW'(i) < cnt_c);
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_val[g] = req.value;
    end else begin : g_mid
      assign left_val[g] = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val[g] = cell_val[g];
    end else begin : g_inner
      assign right_val[g] = cell_val[g+1];
    end

    plws_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .left_val  (left_val[g]),
      .right_val (right_val[g]),
      .ins_val   (req.value),
      .val       (cell_val[g])
    );
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((req_fire && req.operation != OP_SORT) || sort_done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.operation != OP_SORT) begin
      rsp.status     <= status_d;
      rsp.read_value <= rd_d;
      rsp.count      <= CNT_W'(count_next);
    end else if (sort_done) begin
      rsp.status     <= STATUS_OK;
      rsp.read_value <= '0;
      rsp.count      <= CNT_W'(count);
    end
  end

endmodule

FILE: tb/plws_checker.sv
`timescale 1ns / 100ps
// Checker for the positional list with sort: watches both channels, keeps its own
// copy of the sequence and compares every response transfer with the predicted one.
// Depends on plws_pkg for field widths and operation and status codes.
module plws_checker #(
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  input  logic                                 req_ready,
  input  logic [plws_pkg::OP_W-1:0]            req_operation,
  input  logic signed [plws_pkg::POS_W-1:0]    req_position,
  input  logic signed [plws_pkg::VAL_W-1:0]    req_value,
  input  logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  input  logic [plws_pkg::STATUS_W-1:0]        rsp_status,
  input  logic signed [plws_pkg::VAL_W-1:0]    rsp_read_value,
  input  logic [plws_pkg::CNT_W-1:0]           rsp_count,
  output int                                   failures,
  output int                                   pending
);
  import plws_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        count;
  } reply_t;

  logic signed [VAL_W-1:0] seq [DEPTH];
  int                      held;
  reply_t                  replies_due [$];
  reply_t                  want;
  reply_t                  got;

  // Applies one request to the shadow sequence and returns the reply it should give.
  task automatic apply_list_op(input logic [OP_W-1:0] op, input logic signed [POS_W-1:0] p,
                               input logic signed [VAL_W-1:0] v, output reply_t r);
    int pos;
    int i;
    int j;
    logic signed [VAL_W-1:0] key;
    pos          = int'(p);
    r.status     = STATUS_OK;
    r.read_value = '0;
    case (op)
      OP_INSERT: begin
        if (pos < -1 || pos > held - 1) begin
          r.status = STATUS_RANGE;
        end else if (held >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          for (i = held; i > pos + 1; i--) seq[i] = seq[i-1];
          seq[pos+1] = v;
          held++;
        end
      end
      OP_DELETE: begin
        if (pos < 0 || pos > held - 1) begin
          r.status = STATUS_RANGE;
        end else begin
          for (i = pos; i + 1 < held; i++) seq[i] = seq[i+1];
          held--;
        end
      end
      OP_READ: begin
        if (pos < 0 || pos > held - 1) r.status = STATUS_RANGE;
        else r.read_value = seq[pos];
      end
      default: begin
        for (i = 1; i < held; i++) begin
          key = seq[i];
          j   = i;
          while (j > 0 && key < seq[j-1]) begin
            seq[j] = seq[j-1];
            j--;
          end
          seq[j] = key;
        end
      end
    endcase
    r.count = CNT_W'(held);
  endtask

  initial begin
    failures = 0;
    pending  = 0;
    held     = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      held = 0;
      replies_due.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        got = '{rsp_status, rsp_read_value, rsp_count};
        if (replies_due.size() == 0) begin
          $error("response transfer with no request outstanding");
          failures++;
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            failures++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            failures++;
          end
        end
      end
      if (req_valid && req_ready) begin
        apply_list_op(req_operation, req_position, req_value, want);
        replies_due.push_back(want);
      end
    end
    pending = replies_due.size();
  end

endmodule

FILE: tb/tb_positional_list_with_sort.sv
`timescale 1ns / 100ps
// Top of the positional list with sort testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on plws_pkg, plws_if.sv,
// positional_list_with_sort and plws_checker.
module tb_positional_list_with_sort;
  import plws_pkg::*;

  localparam int DEPTH     = 64;
  localparam int N_RANDOM  = 1500;
  localparam int CALM_FROM = 1300;

  typedef enum {
    MIX_GROW,
    MIX_SHRINK,
    MIX_CHURN
  } mix_t;

  logic clk;
  logic rst;
  bit   calm;
  int   failures;
  int   pending;
  int   held;

  plws_req_if req ();
  plws_rsp_if rsp ();

  positional_list_with_sort #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  plws_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_operation (req.operation),
    .req_position  (req.position),
    .req_value     (req.value),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_read_value(rsp.read_value),
    .rsp_count     (rsp.count),
    .failures      (failures),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** positional_list_with_sort: FAILED **");
    $finish;
  end

  // Offers one request, waits for its transfer, then perhaps leaves a gap.
  task automatic send_request(input logic [OP_W-1:0] op, input int pos,
                              input logic [VAL_W-1:0] val);
    req.valid     <= 1'b1;
    req.operation <= op;
    req.position  <= POS_W'(pos);
    req.value     <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (op == OP_INSERT && pos >= -1 && pos <= held - 1 && held < DEPTH) held++;
    if (op == OP_DELETE && pos >= 0 && pos <= held - 1) held--;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, one long hold so the block backs up into the request side.
  initial begin
    int  cyc;
    int  n;
    bit  long_done;
    cyc       = 0;
    long_done = 1'b0;
    rsp.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && !long_done && cyc >= 3000) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        cyc += 400;
        long_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
        cyc += n;
      end else begin
        n = $urandom_range(1, 12);
        rsp.ready <= 1'b1;
        repeat (n) @(posedge clk);
        cyc += n;
      end
    end
  end

  initial begin
    int          k;
    int          r;
    int          pos;
    int          phase_left;
    int          spins;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;
    mix_t        mix;

    calm          = 1'b0;
    held          = 0;
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.operation = OP_READ;
    req.position  = '0;
    req.value     = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty store, both ends, extremes of value and position, sort.
    send_request(OP_READ,   0,   32'h0);
    send_request(OP_DELETE, 0,   32'h0);
    send_request(OP_SORT,   5,   32'h1234_5678);
    send_request(OP_INSERT, 0,   32'h1);
    send_request(OP_INSERT, -64, 32'h2);
    send_request(OP_INSERT, -1,  32'h7fff_ffff);
    send_request(OP_SORT,   -1,  32'hffff_ffff);
    send_request(OP_INSERT, 0,   32'h8000_0000);
    send_request(OP_INSERT, -1,  32'h0);
    send_request(OP_INSERT, 2,   32'hffff_ffff);
    send_request(OP_INSERT, 63,  32'h5);
    send_request(OP_READ,   4,   32'h0);
    for (k = 0; k < 4; k++) send_request(OP_READ, k, 32'h0);
    send_request(OP_SORT,   0,   32'h0);
    for (k = 0; k < 4; k++) send_request(OP_READ, k, 32'h0);
    send_request(OP_DELETE, 3,   32'h0);
    send_request(OP_DELETE, 0,   32'h0);
    send_request(OP_DELETE, 63,  32'h0);
    send_request(OP_READ,   -1,  32'h0);
    send_request(OP_INSERT, -2,  32'h0);

    // Random: phases that grow, shrink or churn the sequence. The first one grows it.
    mix        = MIX_GROW;
    phase_left = 110;
    for (k = 0; k < N_RANDOM; k++) begin
      if (phase_left == 0) begin
        r          = $urandom_range(0, 2);
        mix        = (r == 0) ? MIX_GROW : (r == 1) ? MIX_SHRINK : MIX_CHURN;
        phase_left = $urandom_range(40, 150);
      end
      phase_left--;
      calm = (k >= CALM_FROM);

      r = $urandom_range(0, 99);
      case (mix)
        MIX_GROW:   op = (r < 75) ? OP_INSERT : (r < 85) ? OP_READ :
                         (r < 94) ? OP_DELETE : OP_SORT;
        MIX_SHRINK: op = (r < 15) ? OP_INSERT : (r < 30) ? OP_READ :
                         (r < 93) ? OP_DELETE : OP_SORT;
        default:    op = (r < 40) ? OP_INSERT : (r < 65) ? OP_READ :
                         (r < 93) ? OP_DELETE : OP_SORT;
      endcase

      // Mostly positions in range; sorts and a fifth of the rest take any 7-bit pattern.
      if (op == OP_SORT || $urandom_range(0, 4) == 0) begin
        r   = $urandom_range(0, 127);
        pos = (r >= 64) ? r - 128 : r;
      end else if (op == OP_INSERT) begin
        pos = int'($urandom_range(0, held)) - 1;
      end else begin
        pos = (held > 0) ? int'($urandom_range(0, held - 1)) : 0;
      end

      // Narrow values now and then, so that the sort meets equal keys.
      case ($urandom_range(0, 3))
        0: val = VAL_W'(int'($urandom_range(0, 16)) - 8);
        1: begin
          r = $urandom_range(0, 3);
          val = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7fff_ffff :
                (r == 2) ? 32'h0 : 32'hffff_ffff;
        end
        default: val = $urandom;
      endcase

      send_request(op, pos, val);
    end
    req.valid <= 1'b0;

    spins = 0;
    while (pending != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    repeat (DEPTH + 16) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("** positional_list_with_sort: PASSED **");
    end else begin
      $display("** positional_list_with_sort: FAILED **");
    end
    $finish;
  end

endmodule
